FILE: design/abra_pkg.sv
// types and constants shared by the audio buffer ram allocator
// request and response payloads, table entry layout, opcode, mode and status codes
// no dependencies
package abra_pkg;

    localparam int ID_W    = 8;
    localparam int BYTES_W = 31;
    localparam int FREE_W  = 27;

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_DELETE   = 3'd1;
    localparam logic [2:0] OP_SET_MODE = 3'd2;
    localparam logic [2:0] OP_GET_MODE = 3'd3;
    localparam logic [2:0] OP_LOAD     = 3'd4;

    localparam logic [1:0] MODE_AUTO    = 2'd0;
    localparam logic [1:0] MODE_HW      = 2'd1;
    localparam logic [1:0] MODE_ACC     = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_BAD_MODE = 3'd1;
    localparam logic [2:0] STATUS_UNKNOWN  = 3'd2;
    localparam logic [2:0] STATUS_FILLED   = 3'd3;
    localparam logic [2:0] STATUS_NO_MEM   = 3'd4;
    localparam logic [2:0] STATUS_NULL_ID  = 3'd5;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [ID_W-1:0]    buffer_id;
        logic [1:0]         mode;
        logic [BYTES_W-1:0] data_bytes;
    } abra_req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [1:0]        mode_out;
        logic              on_card;
        logic [FREE_W-1:0] free_bytes;
    } abra_rsp_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic               on_card;
        logic               dirty;
        logic [BYTES_W-1:0] size;
    } abra_entry_t;

endpackage

FILE: design/audio_buffer_ram_allocator.sv
// audio buffer ram allocator top level: buffer table memory, valid bits, free byte counter
// depends on abra_pkg
//
// Each request is one buffer operation (create, delete, set mode, get mode, load) and gives
// one response with a status, the stored mode for get mode, the on-card flag of the buffer
// and the free on-card bytes left. A request first does the registered read of the buffer
// table memory, then updates the entry, its valid bit and the free counter and loads the
// response register once the response side can take it; no new request is taken until
// then. Valid bits sit in flip-flops and clear at reset, so no clearing pass is needed.
// Ids at or above NUM_BUFFERS report an unknown buffer unless a bad mode is found first.
module audio_buffer_ram_allocator #(
    parameter int NUM_BUFFERS = 256,
    parameter int RAM_BYTES   = 67108864
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  abra_pkg::abra_req_t  s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output abra_pkg::abra_rsp_t  m_payload
);
    import abra_pkg::*;

    localparam int DEPTH = (NUM_BUFFERS < (1 << ID_W)) ? NUM_BUFFERS : (1 << ID_W);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(RAM_BYTES + 1);
    localparam int SUM_W = 34;
    localparam logic [SUM_W-1:0] RAM_MAX = SUM_W'(RAM_BYTES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    abra_entry_t mem [DEPTH];
    abra_entry_t rdata_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0] free_reg;
    logic state_reg;
    logic state_next;
    abra_req_t req_reg;
    logic m_valid_reg;
    abra_rsp_t m_payload_reg;

    logic [IDX_W-1:0] s_idx;
    logic [IDX_W-1:0] idx;
    logic in_range;
    logic null_id;
    logic ent_valid;
    abra_entry_t ent;
    abra_entry_t ent_new;
    logic valid_new;
    logic write_en;
    logic [2:0] status;
    logic [1:0] mode_out;
    logic [SUM_W-1:0] add_bytes;
    logic [SUM_W-1:0] sub_bytes;
    logic [SUM_W-1:0] free_ext;
    logic [SUM_W-1:0] bytes_ext;
    logic [SUM_W-1:0] old_size;
    logic [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0] diff;
    logic [SUM_W-1:0] free_new;
    logic finish;

    assign s_idx     = s_payload.buffer_id[IDX_W-1:0];
    assign idx       = req_reg.buffer_id[IDX_W-1:0];
    assign in_range  = 32'(req_reg.buffer_id) < 32'(NUM_BUFFERS);
    assign null_id   = req_reg.buffer_id == '0;
    assign ent_valid = in_range && valid_reg[idx];
    assign ent       = ent_valid ? rdata_reg : '0;
    assign free_ext  = SUM_W'(free_reg);
    assign bytes_ext = SUM_W'(req_reg.data_bytes);
    assign old_size  = ent.on_card ? SUM_W'(ent.size) : '0;

    assign s_ready = (state_reg == ST_IDLE);
    assign finish  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        status    = STATUS_OK;
        mode_out  = MODE_AUTO;
        ent_new   = ent;
        valid_new = ent_valid;
        write_en  = 1'b0;
        add_bytes = '0;
        sub_bytes = '0;
        if (req_reg.opcode <= OP_LOAD) begin
            if (req_reg.opcode == OP_SET_MODE && req_reg.mode == MODE_INVALID) begin
                status = STATUS_BAD_MODE;
            end else if (null_id) begin
                status = STATUS_NULL_ID;
            end else if (req_reg.opcode == OP_GET_MODE && req_reg.mode == MODE_INVALID) begin
                status = STATUS_BAD_MODE;
            end else if (!in_range) begin
                status = STATUS_UNKNOWN;
            end else if (req_reg.opcode == OP_CREATE) begin
                if (!ent_valid) begin
                    ent_new   = '0;
                    valid_new = 1'b1;
                    write_en  = 1'b1;
                end
            end else if (!ent_valid) begin
                status = STATUS_UNKNOWN;
            end else begin
                case (req_reg.opcode)
                    OP_DELETE: begin
                        add_bytes = old_size;
                        ent_new   = '0;
                        valid_new = 1'b0;
                    end
                    OP_SET_MODE: begin
                        if (ent.dirty) begin
                            status = STATUS_FILLED;
                        end else begin
                            ent_new.mode = req_reg.mode;
                            write_en     = 1'b1;
                        end
                    end
                    OP_GET_MODE: begin
                        mode_out = ent.mode;
                    end
                    default: begin
                        ent_new.size  = req_reg.data_bytes;
                        ent_new.dirty = 1'b1;
                        write_en      = 1'b1;
                        case (ent.mode)
                            MODE_AUTO: begin
                                if (!ent.dirty) begin
                                    if (free_ext >= bytes_ext) begin
                                        ent_new.on_card = 1'b1;
                                        sub_bytes       = bytes_ext;
                                    end
                                end else begin
                                    ent_new.on_card = 1'b0;
                                    add_bytes       = old_size;
                                end
                            end
                            MODE_HW: begin
                                if (free_ext < bytes_ext) begin
                                    status   = STATUS_NO_MEM;
                                    ent_new  = ent;
                                    write_en = 1'b0;
                                end else begin
                                    ent_new.on_card = 1'b1;
                                    add_bytes       = old_size;
                                    sub_bytes       = bytes_ext;
                                end
                            end
                            default: begin
                                ent_new.on_card = 1'b0;
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    // saturate the counter to 0..RAM_BYTES
    always_comb begin
        pos_sum = free_ext + add_bytes;
        diff    = pos_sum - sub_bytes;
        if (pos_sum < sub_bytes) begin
            free_new = '0;
        end else if (diff > RAM_MAX) begin
            free_new = RAM_MAX;
        end else begin
            free_new = diff;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rdata_reg <= mem[s_idx];
            req_reg   <= s_payload;
        end
        if (finish && write_en) begin
            mem[idx] <= ent_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_payload_reg.status     <= status;
            m_payload_reg.mode_out   <= mode_out;
            m_payload_reg.on_card    <= in_range && valid_new && ent_new.on_card;
            m_payload_reg.free_bytes <= free_new[FREE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
            free_reg    <= CNT_W'(RAM_BYTES);
        end else begin
            state_reg <= state_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
                free_reg    <= free_new[CNT_W-1:0];
                if (in_range) begin
                    valid_reg[idx] <= valid_new;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule
